// File: rtl/core/box_mean_filter_macros.svh
// Assertion macros shared by the box mean filter RTL.
`ifndef BOX_MEAN_FILTER_MACROS_SVH
`define BOX_MEAN_FILTER_MACROS_SVH
// Check that an expression holds at every clock edge outside reset.
`define BMF_CHECK(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("box mean filter check failed");
// Check that a condition is followed by a consequence in the next cycle.
`define BMF_NEXT(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error("box mean filter sequence check failed");
`endif

// File: rtl/core/bmf_pkg.sv
// Shared constants, types and helper functions for the box mean filter.
`default_nettype none
package bmf_pkg;
   localparam int PIX_W = 8;
   localparam int CSUM_W = 11;
   localparam int TOT_W = 14;
   localparam int X_W = 15;
   localparam int RECIP_W = 17;
   localparam int RECIP_SHIFT = 20;
   localparam int CFG_W = 12;
   localparam int POS_W = 11;
   localparam int RAD_W = 2;
   localparam int IDX_W = 3;
   localparam int DEF_MAX_WIDTH = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;
   localparam int DEF_MAX_RADIUS = 3;

   typedef enum logic [IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_WINDOW_RADIUS = 3'd2,
      CSR_CHANNEL_COUNT = 3'd3
   } csr_idx_type;

   // Sideband that travels with one pixel through the pipeline.
   typedef struct packed {
      logic             emit;
      logic             last;
      logic             mono;
      logic [POS_W-1:0] crow;
      logic [POS_W-1:0] ccol;
   } bmf_tag_type;

   // Reciprocal of the window area, ceil(2^20 / (2r+1)^2).
   function automatic logic [RECIP_W-1:0] recip_of(input logic [RAD_W-1:0] r);
      logic [RECIP_W-1:0] m;
      case (r)
         2'd2:    m = 17'd41944;
         2'd3:    m = 17'd21400;
         default: m = 17'd116509;
      endcase
      return m;
   endfunction

   // Half of the window area, for round to nearest.
   function automatic logic [5:0] half_area(input logic [RAD_W-1:0] r);
      logic [5:0] h;
      case (r)
         2'd2:    h = 6'd12;
         2'd3:    h = 6'd24;
         default: h = 6'd4;
      endcase
      return h;
   endfunction
endpackage
`default_nettype wire

// File: rtl/core/bmf_if.sv
// Channel interfaces of the box mean filter: pixel input, mean output, register writes.
`default_nettype none
interface bmf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pix_c0;
   logic [7:0] pix_c1;
   logic [7:0] pix_c2;
   modport source(output valid, pix_c0, pix_c1, pix_c2, input ready);
   modport sink(input valid, pix_c0, pix_c1, pix_c2, output ready);
endinterface

interface bmf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  mean_c0;
   logic [7:0]  mean_c1;
   logic [7:0]  mean_c2;
   logic [10:0] centre_row;
   logic [10:0] centre_col;
   logic        frame_last;
   modport source(output valid, mean_c0, mean_c1, mean_c2, centre_row, centre_col,
                  frame_last, input ready);
   modport sink(input valid, mean_c0, mean_c1, mean_c2, centre_row, centre_col,
                frame_last, output ready);
endinterface

interface bmf_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [11:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bmf_line_lane.sv
// One line buffer row: a pixel memory read before write at the same column.
`default_nettype none
module bmf_line_lane #(
   parameter int MAX_WIDTH = bmf_pkg::DEF_MAX_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         rd_en,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] addr,
   input  wire logic [3*bmf_pkg::PIX_W-1:0]  wdata,
   output logic      [3*bmf_pkg::PIX_W-1:0]  rdata
);
   logic [3*bmf_pkg::PIX_W-1:0] mem [MAX_WIDTH];
   logic [3*bmf_pkg::PIX_W-1:0] rdata_ff;

   // read old contents, then store the new pixel
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
      if (wr_en) begin
         mem[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// File: rtl/core/bmf_div.sv
// Rounded division of one channel total by the window area via reciprocal multiply.
`default_nettype none
module bmf_div (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [bmf_pkg::RAD_W-1:0]    radius,
   input  wire logic [bmf_pkg::X_W-1:0]      x,
   output logic      [bmf_pkg::PIX_W-1:0]    q
);
   localparam int PROD_W = bmf_pkg::X_W + bmf_pkg::RECIP_W;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   // exact floor for all totals a window can reach
   assign prod_in = PROD_W'(x) * PROD_W'(bmf_pkg::recip_of(radius));

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign q = prod_ff[bmf_pkg::RECIP_SHIFT +: bmf_pkg::PIX_W];
endmodule
`default_nettype wire

// File: rtl/core/box_mean_filter.sv
// Top level of the streaming box mean filter.
// Usage: pixels enter on req_if in raster order, one beat per pixel with all three
// channels (only pix_c0 counts in mono mode). Each pixel whose (2r+1)x(2r+1) window
// is complete yields one beat on rsp_if holding the rounded channel means, the
// window centre position, and frame_last on the final result of the frame.
// Border pixels give no beat. Registers are written on csr_if (index, data) while
// the block is idle; every write, also to an unused index, restarts the frame.
// Throughput: one pixel per cycle; the whole pipeline advances together, so a
// stalled rsp_if holds the pipeline and drops req_if.ready until the output beat
// is taken. Once its pixel is accepted, a result moves through line memory read,
// column sum, window sum, reciprocal multiply and output register, in that order.
// Line buffers are 2*MAX_RADIUS memories of MAX_WIDTH pixels, one per stored row,
// read in parallel lanes and merged by the column adder.
// Reset returns the registers to 640x480, radius 1, three channels, and restarts
// the frame; line memories need no clearing because only rows written earlier in
// the same frame are ever used.
`default_nettype none
`include "box_mean_filter_macros.svh"
module box_mean_filter #(
   parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = bmf_pkg::DEF_MAX_RADIUS
) (
   input wire logic  clock,
   input wire logic  reset,
   bmf_req_if.sink   req_if,
   bmf_rsp_if.source rsp_if,
   bmf_csr_if.sink   csr_if
);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int LANES  = 2 * MAX_RADIUS;
   localparam int WIN    = 2 * MAX_RADIUS + 1;
   localparam int SLOT_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int PW     = bmf_pkg::PIX_W;
   localparam int CW     = bmf_pkg::CSUM_W;

   // configuration registers
   logic [bmf_pkg::CFG_W-1:0] fw_ff, fh_ff;
   logic [bmf_pkg::RAD_W-1:0] rad_ff;
   logic                      chan_ff;

   // clamped configuration
   logic [COL_W:0]            w_eff;
   logic [ROW_W:0]            h_eff;
   logic [bmf_pkg::RAD_W-1:0] r_eff;
   logic [3:0]                span;

   // position counters
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic en, accept, csr_we;
   logic col_end, row_end;

   // pipeline registers
   logic                      v1_ff, v2_ff, v3_ff, v4_ff, out_v_ff;
   bmf_pkg::bmf_tag_type      tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag_new;
   logic [3*PW-1:0]           pix1_ff;
   logic [LANES-1:0]          use1_ff;
   logic [3*PW-1:0]           lane_rd [LANES];
   logic [3*CW-1:0]           win_ff [WIN];
   logic [3*CW-1:0]           csum;
   logic [bmf_pkg::RAD_W-1:0] r1_ff, r2_ff, r3_ff;
   logic [bmf_pkg::X_W-1:0]   x_ff [3];
   logic [bmf_pkg::X_W-1:0]   x_in [3];
   logic [PW-1:0]             q [3];
   logic [PW-1:0]             mean_ff [3];
   logic                      last_ff;
   logic [bmf_pkg::POS_W-1:0] crow_ff, ccol_ff;

   // clamp register values into the supported range
   always_comb begin
      if (fw_ff == '0) begin
         w_eff = (COL_W+1)'(1);
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         w_eff = (COL_W+1)'(MAX_WIDTH);
      end else begin
         w_eff = (COL_W+1)'(fw_ff);
      end
      if (fh_ff == '0) begin
         h_eff = (ROW_W+1)'(1);
      end else if (32'(fh_ff) > MAX_HEIGHT) begin
         h_eff = (ROW_W+1)'(MAX_HEIGHT);
      end else begin
         h_eff = (ROW_W+1)'(fh_ff);
      end
      if (rad_ff == '0) begin
         r_eff = bmf_pkg::RAD_W'(1);
      end else if (32'(rad_ff) > MAX_RADIUS) begin
         r_eff = bmf_pkg::RAD_W'(MAX_RADIUS);
      end else begin
         r_eff = rad_ff;
      end
      span = {1'b0, r_eff, 1'b0};
   end

   assign en            = !out_v_ff || rsp_if.ready;
   assign req_if.ready  = en;
   assign accept        = req_if.valid && en;
   assign csr_if.ready  = 1'b1;
   assign csr_we        = csr_if.valid;

   // advance position: column, row and line slot
   always_comb begin
      col_end = ((COL_W+1)'(col_ff) + (COL_W+1)'(1)) == w_eff;
      row_end = ((ROW_W+1)'(row_ff) + (ROW_W+1)'(1)) == h_eff;
      col_in  = col_ff + COL_W'(1);
      row_in  = row_ff;
      slot_in = slot_ff;
      if (col_end) begin
         col_in = '0;
         if (row_end) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in = row_ff + ROW_W'(1);
            if (4'(slot_ff) + 4'd1 == span) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
      end
      tag_new.emit = (32'(row_ff) >= 32'(span)) && (32'(col_ff) >= 32'(span));
      tag_new.last = col_end && row_end;
      tag_new.mono = !chan_ff;
      tag_new.crow = bmf_pkg::POS_W'(32'(row_ff) - 32'(r_eff));
      tag_new.ccol = bmf_pkg::POS_W'(32'(col_ff) - 32'(r_eff));
   end

   // configuration writes and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff   <= bmf_pkg::CFG_W'(640);
         fh_ff   <= bmf_pkg::CFG_W'(480);
         rad_ff  <= bmf_pkg::RAD_W'(1);
         chan_ff <= 1'b1;
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_if.index)
            bmf_pkg::CSR_FRAME_WIDTH:   fw_ff   <= csr_if.data;
            bmf_pkg::CSR_FRAME_HEIGHT:  fh_ff   <= csr_if.data;
            bmf_pkg::CSR_WINDOW_RADIUS: rad_ff  <= csr_if.data[bmf_pkg::RAD_W-1:0];
            bmf_pkg::CSR_CHANNEL_COUNT: chan_ff <= csr_if.data[0];
            default: ;
         endcase
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // line buffer lanes, one per stored row
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      bmf_line_lane #(.MAX_WIDTH(MAX_WIDTH)) u_lane (
         .clock (clock),
         .rd_en (accept),
         .wr_en (accept && (slot_ff == SLOT_W'(i))),
         .addr  (col_ff),
         .wdata ({req_if.pix_c2, req_if.pix_c1, req_if.pix_c0}),
         .rdata (lane_rd[i])
      );
   end

   // stage 1 payload: pixel, lane usage, sideband
   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff <= {req_if.pix_c2, req_if.pix_c1, req_if.pix_c0};
         tag1_ff <= tag_new;
         r1_ff   <= r_eff;
         for (int i = 0; i < LANES; i++) begin
            use1_ff[i] <= (32'(i) < 32'(span)) && (32'(row_ff) >= 32'(span));
         end
      end
   end

   // merge lanes into the column sum per channel
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         csum[c*CW +: CW] = CW'(pix1_ff[c*PW +: PW]);
         for (int i = 0; i < LANES; i++) begin
            if (use1_ff[i]) begin
               csum[c*CW +: CW] = csum[c*CW +: CW] + CW'(lane_rd[i][c*PW +: PW]);
            end
         end
      end
   end

   // window sums plus half area for rounding
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         x_in[c] = bmf_pkg::X_W'(bmf_pkg::half_area(r2_ff));
         for (int k = 0; k < WIN; k++) begin
            if (32'(k) < 32'(2 * r2_ff + 1)) begin
               x_in[c] = x_in[c] + bmf_pkg::X_W'(win_ff[k][c*CW +: CW]);
            end
         end
      end
   end

   // pipeline control and window shift
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k < WIN; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         if (csr_we) begin
            for (int k = 0; k < WIN; k++) begin
               win_ff[k] <= '0;
            end
         end else if (en && v1_ff) begin
            win_ff[0] <= csum;
            for (int k = 1; k < WIN; k++) begin
               win_ff[k] <= win_ff[k-1];
            end
         end
         if (en) begin
            v1_ff    <= accept;
            v2_ff    <= v1_ff && tag1_ff.emit;
            v3_ff    <= v2_ff;
            v4_ff    <= v3_ff;
            out_v_ff <= v4_ff;
         end
      end
   end

   // stage payloads after the window
   always_ff @(posedge clock) begin
      if (en) begin
         tag2_ff <= tag1_ff;
         r2_ff   <= r1_ff;
         tag3_ff <= tag2_ff;
         r3_ff   <= r2_ff;
         tag4_ff <= tag3_ff;
         for (int c = 0; c < 3; c++) begin
            x_ff[c]    <= x_in[c];
            mean_ff[c] <= (c > 0 && tag4_ff.mono) ? '0 : q[c];
         end
         last_ff <= tag4_ff.last;
         crow_ff <= tag4_ff.crow;
         ccol_ff <= tag4_ff.ccol;
      end
   end

   // divide each channel total by the window area
   for (genvar c = 0; c < 3; c++) begin : g_div
      bmf_div u_div (
         .clock  (clock),
         .en     (en),
         .radius (r3_ff),
         .x      (x_ff[c]),
         .q      (q[c])
      );
   end

   assign rsp_if.valid      = out_v_ff;
   assign rsp_if.mean_c0    = mean_ff[0];
   assign rsp_if.mean_c1    = mean_ff[1];
   assign rsp_if.mean_c2    = mean_ff[2];
   assign rsp_if.centre_row = crow_ff;
   assign rsp_if.centre_col = ccol_ff;
   assign rsp_if.frame_last = last_ff;

   `BMF_CHECK(a_slot_in_span, 4'(slot_ff) < span)
   `BMF_CHECK(a_col_in_width, (COL_W+1)'(col_ff) < w_eff)
   `BMF_CHECK(a_stall_blocks_input, !(out_v_ff && !rsp_if.ready) || !req_if.ready)
   `BMF_NEXT(a_csr_restarts, csr_we, col_ff == '0 && row_ff == '0 && slot_ff == '0)
endmodule
`default_nettype wire

// File: verif/tb_box_mean_filter.sv
// Self-checking testbench for the box mean filter: raster stimulus, window-mean prediction.
`default_nettype none
module tb_box_mean_filter;

   localparam int LIMIT_CYCLES = 600000;
   localparam int ITEM_TARGET = 1950;
   localparam int STORE_W = 2048;
   localparam int STORE_ROWS = 6;
   localparam int WIN_COLS = 7;
   localparam logic [bmf_pkg::IDX_W-1:0] CSR_SPARE = 3'd6;

   typedef struct packed {
      logic [7:0]  m0;
      logic [7:0]  m1;
      logic [7:0]  m2;
      logic [10:0] crow;
      logic [10:0] ccol;
      logic        last;
   } mean_beat_type;

   typedef struct packed {
      logic [23:0]   px;
      logic          typed;
      mean_beat_type want;
   } pixel_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int unsigned cycles = 0;
   int errors = 0;
   int got_beats = 0;
   bit sending_done = 1'b0;

   bmf_req_if req();
   bmf_rsp_if rsp();
   bmf_csr_if csr();

   box_mean_filter DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req),
      .rsp_if(rsp),
      .csr_if(csr)
   );

   // Shadow registers and filter state
   logic [11:0] width_reg = 12'd640;
   logic [11:0] height_reg = 12'd480;
   logic [1:0]  radius_reg = 2'd1;
   logic        color_reg = 1'b1;
   logic [23:0] line_mem [STORE_ROWS][STORE_W];
   logic [32:0] col_sums [WIN_COLS];
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   mean_beat_type mean_q [$];

   always #1 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d (beat %0d)", what, got, want, got_beats);
      errors++;
   endtask

   task automatic restart_frame();
      col_pos = 0;
      row_pos = 0;
      foreach (col_sums[k]) col_sums[k] = '0;
   endtask

   // Advance the window model by one pixel; return whether a mean is due
   function automatic bit window_mean(input logic [23:0] px, output mean_beat_type res);
      int unsigned r, span, side, area, w, h, col, row, slot, m;
      int unsigned csum[3];
      int unsigned tot[3];
      logic [23:0] word;
      r = (radius_reg == 0) ? 1 : radius_reg;
      span = 2 * r;
      side = span + 1;
      area = side * side;
      w = (width_reg == 0) ? 1 : ((width_reg > STORE_W) ? STORE_W : width_reg);
      h = (height_reg == 0) ? 1 : ((height_reg > 2048) ? 2048 : height_reg);
      col = (col_pos >= w) ? 0 : col_pos;
      row = (row_pos >= h) ? 0 : row_pos;
      res = '0;
      for (int ch = 0; ch < 3; ch++) csum[ch] = px[8*ch +: 8];
      // add the stored rows above
      if (row >= span) begin
         for (int k = 1; k <= span; k++) begin
            slot = (row - k) % span;
            word = line_mem[slot][col];
            for (int ch = 0; ch < 3; ch++) csum[ch] += word[8*ch +: 8];
         end
      end
      line_mem[row % span][col] = px;
      for (int k = WIN_COLS - 1; k > 0; k--) col_sums[k] = col_sums[k-1];
      col_sums[0] = {csum[2][10:0], csum[1][10:0], csum[0][10:0]};
      window_mean = 1'b0;
      if (row >= span && col >= span) begin
         tot = '{0, 0, 0};
         for (int k = 0; k < side; k++)
            for (int ch = 0; ch < 3; ch++) tot[ch] += col_sums[k][11*ch +: 11];
         for (int ch = 0; ch < 3; ch++) begin
            m = (tot[ch] + area / 2) / area;
            if (m > 255) m = 255;
            if (!color_reg && ch > 0) m = 0;
            case (ch)
               0: res.m0 = m[7:0];
               1: res.m1 = m[7:0];
               default: res.m2 = m[7:0];
            endcase
         end
         res.crow = 11'(row - r);
         res.ccol = 11'(col - r);
         res.last = (row == h - 1 && col == w - 1);
         window_mean = 1'b1;
      end
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      col_pos = col;
      row_pos = row;
   endfunction

   // Register write beat; valid stays high for the caller to drop after a batch
   task automatic csr_write(input logic [bmf_pkg::IDX_W-1:0] idx, input logic [11:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      case (idx)
         bmf_pkg::CSR_FRAME_WIDTH: width_reg = value;
         bmf_pkg::CSR_FRAME_HEIGHT: height_reg = value;
         bmf_pkg::CSR_WINDOW_RADIUS: radius_reg = value[1:0];
         bmf_pkg::CSR_CHANNEL_COUNT: color_reg = value[0];
         default: ;
      endcase
      restart_frame();
   endtask

   task automatic configure(input logic [11:0] w, input logic [11:0] h,
                            input logic [1:0] r, input logic c, input bit spare);
      csr_write(bmf_pkg::CSR_FRAME_WIDTH, w);
      csr_write(bmf_pkg::CSR_FRAME_HEIGHT, h);
      csr_write(bmf_pkg::CSR_WINDOW_RADIUS, {10'd0, r});
      csr_write(bmf_pkg::CSR_CHANNEL_COUNT, {11'd0, c});
      if (spare) csr_write(CSR_SPARE, 12'(($urandom)));
      csr.valid <= 1'b0;
   endtask

   // Drain outstanding means, then let the pipeline empty before a register write
   task automatic drain();
      wait (mean_q.size() == 0);
      repeat (10) @(posedge clock);
   endtask

   // Offer one pixel beat; returns the predicted mean if one is due
   task automatic send_pixel(input logic [23:0] px, input bit burst,
                             output bit due, output mean_beat_type res);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.pix_c0 <= px[7:0];
      req.pix_c1 <= px[15:8];
      req.pix_c2 <= px[23:16];
      do @(posedge clock); while (!req.ready);
      due = window_mean(px, res);
      if (due) mean_q.push_back(res);
   endtask

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 7))
         0: rand_chan = 8'd0;
         1: rand_chan = 8'd255;
         default: rand_chan = 8'($urandom);
      endcase
   endfunction

   // Directed frames: full white, full black, then mono white
   pixel_row_type directed [27];
   initial begin
      for (int i = 0; i < 27; i++) begin
         directed[i].px = (i >= 9 && i < 18) ? 24'h000000 : 24'hFFFFFF;
         directed[i].typed = (i % 9 == 8);
         directed[i].want = '{m0: (i < 9 || i >= 18) ? 8'd255 : 8'd0,
                              m1: (i < 9) ? 8'd255 : 8'd0,
                              m2: (i < 9) ? 8'd255 : 8'd0,
                              crow: 11'd1, ccol: 11'd1, last: 1'b1};
      end
   end

   // Stimulus
   initial begin
      bit due, burst;
      mean_beat_type res;
      int sent, n, wsel, hsel;
      logic [11:0] w, h;
      logic [1:0] r;
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (col_sums[k]) col_sums[k] = '0;
      req.valid <= 1'b0;
      req.pix_c0 <= '0;
      req.pix_c1 <= '0;
      req.pix_c2 <= '0;
      csr.valid <= 1'b0;
      csr.index <= '0;
      csr.data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      for (int i = 0; i < 27; i++) begin
         if (i == 0) configure(12'd3, 12'd3, 2'd1, 1'b1, 1'b0);
         if (i == 18) begin
            req.valid <= 1'b0;
            drain();
            configure(12'd3, 12'd3, 2'd1, 1'b0, 1'b0);
         end
         send_pixel(directed[i].px, i[0], due, res);
         if (directed[i].typed && (!due || res != directed[i].want))
            report("directed mean_c0", int'(res.m0), int'(directed[i].want.m0));
      end
      req.valid <= 1'b0;
      drain();

      // Random phases
      sent = 0;
      while (sent < ITEM_TARGET) begin
         wsel = $urandom_range(0, 9);
         hsel = $urandom_range(0, 9);
         w = (wsel == 0) ? 12'd0 : (wsel == 1) ? 12'd4095 : (wsel == 2) ? 12'd1
           : 12'($urandom_range(5, 24));
         h = (hsel == 0) ? 12'd0 : (hsel == 1) ? 12'd4095 : 12'($urandom_range(5, 12));
         r = 2'($urandom_range(0, 3));
         configure(w, h, r, 1'($urandom), ($urandom_range(0, 4) == 0));
         n = (w > 100 || w < 2) ? 120 : int'(w) * $urandom_range(8, 20);
         if (n > 300) n = 300;
         burst = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < n; i++)
            send_pixel({rand_chan(), rand_chan(), rand_chan()}, burst, due, res);
         req.valid <= 1'b0;
         sent += n;
         drain();
      end
      sending_done = 1'b1;
   end

   // Mean beat sink with random stalls and one long hold-off
   initial begin
      int gap;
      bit held, calm;
      mean_beat_type want;
      held = 1'b0;
      calm = 1'b0;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (got_beats % 50 == 0) calm = ($urandom_range(0, 2) == 0);
         gap = calm ? 0 : $urandom_range(0, 14);
         if (!held && got_beats == 60) begin
            gap = 300;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         if (mean_q.size() == 0) begin
            report("unexpected beat row", rsp.centre_row, -1);
         end else begin
            want = mean_q.pop_front();
            if (rsp.mean_c0 !== want.m0) report("mean_c0", rsp.mean_c0, want.m0);
            if (rsp.mean_c1 !== want.m1) report("mean_c1", rsp.mean_c1, want.m1);
            if (rsp.mean_c2 !== want.m2) report("mean_c2", rsp.mean_c2, want.m2);
            if (rsp.centre_row !== want.crow) report("centre_row", rsp.centre_row, want.crow);
            if (rsp.centre_col !== want.ccol) report("centre_col", rsp.centre_col, want.ccol);
            if (rsp.frame_last !== want.last) report("frame_last", rsp.frame_last, want.last);
         end
         got_beats++;
      end
   end

   // Final verdict
   initial begin
      wait (sending_done);
      wait (mean_q.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: box_mean_filter.f
+incdir+rtl/core
rtl/core/bmf_pkg.sv
rtl/core/bmf_if.sv
rtl/core/bmf_line_lane.sv
rtl/core/bmf_div.sv
rtl/core/box_mean_filter.sv
verif/tb_box_mean_filter.sv
